@@ rtl/line_pixel_rasterizer_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Line pixel rasterizer assertion macros
// Shared concurrent assertion forms used by the rasterizer modules.
// ---------------------------------------------------------------------------
`ifndef LINE_PIXEL_RASTERIZER_UNIT_DEFINES_SVH
`define LINE_PIXEL_RASTERIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LPR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lpr_pkg.sv @@
// ---------------------------------------------------------------------------
// Line pixel rasterizer package
// Beat types, line setup bundle and request codes shared by the rasterizer.
// ---------------------------------------------------------------------------
package lpr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int COLOUR_BITS = 32;
  localparam int DELTA_BITS  = COORD_BITS + 1;
  localparam int INCR_BITS   = COORD_BITS + 2;
  localparam int ERR_BITS    = COORD_BITS + 3;

  localparam logic REQ_LINE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic                          req_type;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic        [COLOUR_BITS-1:0] line_colour;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  pixel_x;
    logic signed [COORD_BITS-1:0]  pixel_y;
    logic        [COLOUR_BITS-1:0] pixel_colour;
    logic                          last_pixel;
  } out_item_t;

  typedef struct packed {
    logic                         single;
    logic                         swapped;
    logic signed [COORD_BITS-1:0] major_pos;
    logic signed [COORD_BITS-1:0] major_end;
    logic signed [COORD_BITS-1:0] minor_pos;
    logic                         minor_up;
    logic        [DELTA_BITS-1:0] major_delta;
    logic        [INCR_BITS-1:0]  error_incr;
  } line_setup_t;

endpackage

@@ rtl/lpr_setup.sv @@
// ---------------------------------------------------------------------------
// Line setup
// Chooses the major axis, orders the endpoints and derives the error terms.
// ---------------------------------------------------------------------------
module lpr_setup (
  input  lpr_pkg::in_item_t    item,
  output lpr_pkg::line_setup_t setup
);

  logic signed [lpr_pkg::DELTA_BITS-1:0] dx;
  logic signed [lpr_pkg::DELTA_BITS-1:0] dy;
  logic        [lpr_pkg::DELTA_BITS-1:0] adx;
  logic        [lpr_pkg::DELTA_BITS-1:0] ady;
  logic signed [lpr_pkg::COORD_BITS-1:0] a1;
  logic signed [lpr_pkg::COORD_BITS-1:0] b1;
  logic signed [lpr_pkg::COORD_BITS-1:0] a2;
  logic signed [lpr_pkg::COORD_BITS-1:0] b2;
  logic signed [lpr_pkg::COORD_BITS-1:0] oa1;
  logic signed [lpr_pkg::COORD_BITS-1:0] ob1;
  logic signed [lpr_pkg::COORD_BITS-1:0] oa2;
  logic signed [lpr_pkg::COORD_BITS-1:0] ob2;
  logic                                  swapped;
  logic                                  flip;

  always_comb begin
    dx  = {item.end_x[lpr_pkg::COORD_BITS-1], item.end_x}
        - {item.start_x[lpr_pkg::COORD_BITS-1], item.start_x};
    dy  = {item.end_y[lpr_pkg::COORD_BITS-1], item.end_y}
        - {item.start_y[lpr_pkg::COORD_BITS-1], item.start_y};
    adx = dx[lpr_pkg::DELTA_BITS-1] ? (~dx + 1'b1) : dx;
    ady = dy[lpr_pkg::DELTA_BITS-1] ? (~dy + 1'b1) : dy;
    swapped = adx < ady;
    flip    = swapped ? dy[lpr_pkg::DELTA_BITS-1] : dx[lpr_pkg::DELTA_BITS-1];

    if (swapped) begin
      a1 = item.start_y;
      b1 = item.start_x;
      a2 = item.end_y;
      b2 = item.end_x;
    end else begin
      a1 = item.start_x;
      b1 = item.start_y;
      a2 = item.end_x;
      b2 = item.end_y;
    end

    if (flip) begin
      oa1 = a2;
      ob1 = b2;
      oa2 = a1;
      ob2 = b1;
    end else begin
      oa1 = a1;
      ob1 = b1;
      oa2 = a2;
      ob2 = b2;
    end

    setup.single      = (dx == '0) && (dy == '0);
    setup.swapped     = swapped;
    setup.major_pos   = oa1;
    setup.major_end   = oa2;
    setup.minor_pos   = ob1;
    setup.minor_up    = ob2 > ob1;
    setup.major_delta = swapped ? ady : adx;
    setup.error_incr  = {(swapped ? adx : ady), 1'b0};
  end

endmodule

@@ rtl/lpr_stepper.sv @@
// ---------------------------------------------------------------------------
// Line stepper
// Holds the line state, forms one pixel per beat and advances the error term.
// ---------------------------------------------------------------------------
`include "line_pixel_rasterizer_unit_defines.svh"

module lpr_stepper (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  lpr_pkg::in_item_t    item,
  output logic                 has_result,
  output lpr_pkg::out_item_t   result
);

  localparam int SUM_BITS = lpr_pkg::ERR_BITS + 1;

  lpr_pkg::line_setup_t setup;

  logic                                    busy;
  logic signed [lpr_pkg::COORD_BITS-1:0]   major_pos;
  logic signed [lpr_pkg::COORD_BITS-1:0]   major_end;
  logic signed [lpr_pkg::COORD_BITS-1:0]   minor_pos;
  logic                                    minor_up;
  logic                                    axes_swapped;
  logic signed [lpr_pkg::ERR_BITS-1:0]     error_acc;
  logic        [lpr_pkg::INCR_BITS-1:0]    error_incr;
  logic        [lpr_pkg::DELTA_BITS-1:0]   major_delta;
  logic        [lpr_pkg::COLOUR_BITS-1:0]  held_colour;

  logic                                    cmd;
  logic                                    last;
  logic                                    busy_next;
  logic                                    load;
  logic signed [lpr_pkg::COORD_BITS-1:0]   src_major;
  logic signed [lpr_pkg::COORD_BITS-1:0]   src_end;
  logic signed [lpr_pkg::COORD_BITS-1:0]   src_minor;
  logic                                    src_up;
  logic                                    src_swapped;
  logic signed [lpr_pkg::ERR_BITS-1:0]     src_acc;
  logic        [lpr_pkg::INCR_BITS-1:0]    src_incr;
  logic        [lpr_pkg::DELTA_BITS-1:0]   src_delta;
  logic signed [SUM_BITS-1:0]              sum;
  logic                                    minor_step;
  logic signed [lpr_pkg::ERR_BITS-1:0]     error_acc_next;
  logic signed [lpr_pkg::COORD_BITS-1:0]   minor_pos_next;
  logic signed [lpr_pkg::COORD_BITS-1:0]   major_pos_next;

  lpr_setup u_setup (
    .item  (item),
    .setup (setup)
  );

  always_comb begin
    cmd = item.req_type == lpr_pkg::REQ_LINE;

    if (cmd) begin
      src_major   = setup.major_pos;
      src_end     = setup.major_end;
      src_minor   = setup.minor_pos;
      src_up      = setup.minor_up;
      src_swapped = setup.swapped;
      src_acc     = '0;
      src_incr    = setup.error_incr;
      src_delta   = setup.major_delta;
      last        = setup.single;
    end else begin
      src_major   = major_pos;
      src_end     = major_end;
      src_minor   = minor_pos;
      src_up      = minor_up;
      src_swapped = axes_swapped;
      src_acc     = error_acc;
      src_incr    = error_incr;
      src_delta   = major_delta;
      last        = major_pos >= major_end;
    end

    has_result = cmd | busy;
    result.pixel_x      = src_swapped ? src_minor : src_major;
    result.pixel_y      = src_swapped ? src_major : src_minor;
    result.pixel_colour = cmd ? item.line_colour : held_colour;
    result.last_pixel   = last;

    sum = {src_acc[lpr_pkg::ERR_BITS-1], src_acc}
        + $signed({{(SUM_BITS-lpr_pkg::INCR_BITS){1'b0}}, src_incr});
    minor_step = sum > $signed({{(SUM_BITS-lpr_pkg::DELTA_BITS){1'b0}}, src_delta});
    if (minor_step) begin
      error_acc_next = lpr_pkg::ERR_BITS'(sum
        - $signed({{(SUM_BITS-lpr_pkg::DELTA_BITS-1){1'b0}}, src_delta, 1'b0}));
      minor_pos_next = src_up ? src_minor + 1'b1 : src_minor - 1'b1;
    end else begin
      error_acc_next = lpr_pkg::ERR_BITS'(sum);
      minor_pos_next = src_minor;
    end
    major_pos_next = src_major + 1'b1;

    busy_next = cmd ? ~setup.single : (busy & ~last);
    load      = cmd | (busy & ~last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (fire) begin
      busy <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && load) begin
      major_pos    <= major_pos_next;
      major_end    <= src_end;
      minor_pos    <= minor_pos_next;
      minor_up     <= src_up;
      axes_swapped <= src_swapped;
      error_acc    <= error_acc_next;
      error_incr   <= src_incr;
      major_delta  <= src_delta;
    end
    if (fire && cmd) begin
      held_colour <= item.line_colour;
    end
  end

  `LPR_ASSERT_NEXT(a_major_steps, clk, rst,
    fire && !cmd && busy && !last, major_pos == $past(major_pos) + 1'b1,
    "major coordinate did not advance by one on a tick")

  `LPR_ASSERT_NEXT(a_single_idles, clk, rst,
    fire && cmd && setup.single, !busy,
    "single-pixel line left the stepper busy")

  `LPR_ASSERT_NEXT(a_last_ends_line, clk, rst,
    fire && !cmd && busy && last, !busy,
    "final pixel of a line left the stepper busy")

endmodule

@@ rtl/line_pixel_rasterizer_unit.sv @@
// ---------------------------------------------------------------------------
// Line pixel rasterizer unit
// Bresenham line rasterizer giving at most one pixel beat per accepted beat.
//
// An input beat with req_type REQ_LINE carries two endpoints and a colour;
// it starts a new line, abandoning any line in progress, and yields the
// first pixel. A beat with req_type REQ_TICK yields the next pixel of the
// current line, or no output beat when no line is in progress. The final
// pixel of a line has last_pixel set.
// Each accepted beat is captured in an input register and, once the output
// register is free, processed from there into the output register. One
// beat is accepted every cycle while the output does not stall; the error
// update in the stepper is combinational and does not limit that rate.
// A stall on the output while it holds a pixel holds the output register
// and the input register; in_stall follows out_stall in the same cycle
// whenever both registers hold a beat, so one more beat is taken only
// while the input register is empty.
// Reset empties both registers and ends any line in progress.
// ---------------------------------------------------------------------------
`include "line_pixel_rasterizer_unit_defines.svh"

module line_pixel_rasterizer_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpr_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lpr_pkg::out_item_t  out_item
);

  logic                s1_valid;
  lpr_pkg::in_item_t   s1_item;
  logic                out_free;
  logic                s1_fire;
  logic                has_result;
  lpr_pkg::out_item_t  result;

  assign out_free = ~out_valid | ~out_stall;
  assign s1_fire  = s1_valid & out_free;
  assign in_stall = s1_valid & ~out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  lpr_stepper u_stepper (
    .clk        (clk),
    .rst        (rst),
    .fire       (s1_fire),
    .item       (s1_item),
    .has_result (has_result),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_fire & has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_result) begin
      out_item <= result;
    end
  end

  `LPR_ASSERT_NOW(a_stall_needs_item, clk, rst,
    in_stall, s1_valid && out_valid,
    "input stalled without a held beat and a held result")

  `LPR_ASSERT_NEXT(a_held_beat_kept, clk, rst,
    s1_valid && !out_free, s1_valid && $stable(s1_item),
    "input register lost a beat while the output was blocked")

  `LPR_ASSERT_NEXT(a_result_lands, clk, rst,
    s1_fire && has_result, out_valid,
    "processed beat with a pixel did not reach the output register")

endmodule

@@ dv/line_pixel_rasterizer_unit_test.sv @@
// ---------------------------------------------------------------------------
// Line pixel rasterizer unit testbench
// Sends line commands and ticks to the rasterizer under varying idle and
// stall patterns. Each pixel beat is checked against a cycle-free Bresenham
// predictor or a given pixel. A short directed table covers single points,
// extreme coordinates, steep and diagonal lines, idle ticks, aborted lines.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_pixel_rasterizer_unit_test;

  localparam int N_ITEMS = 1750;

  typedef enum logic [1:0] {BY_MODEL, NO_PIXEL, GIVEN_PIXEL} row_check_t;

  typedef struct packed {
    lpr_pkg::in_item_t  beat;
    row_check_t         check;
    lpr_pkg::out_item_t pix;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  lpr_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  lpr_pkg::out_item_t out_item;

  row_check_t         beat_check = BY_MODEL;
  lpr_pkg::out_item_t given_pix = '0;

  // Predictor state, at the widths the block holds.
  logic                                  line_busy;
  logic signed [lpr_pkg::COORD_BITS-1:0] maj_pos, maj_end, min_pos;
  logic                                  min_up, swapped;
  logic signed [lpr_pkg::ERR_BITS-1:0]   err_acc;
  logic        [lpr_pkg::INCR_BITS-1:0]  err_incr;
  logic        [lpr_pkg::DELTA_BITS-1:0] maj_delta;
  logic        [lpr_pkg::COLOUR_BITS-1:0] colour_held;

  lpr_pkg::out_item_t expected_pixels[$];
  stim_row_t          stim_table[$];
  int                 mismatches = 0;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  bit                 pressure_go = 1'b0;
  bit                 pressure_done = 1'b0;
  int                 hold_left = 0;

  lpr_pkg::out_item_t pred_pix;
  bit                 pred_some;
  lpr_pkg::out_item_t exp_pix;

  line_pixel_rasterizer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic lpr_pkg::out_item_t pixel_at(
      input logic signed [lpr_pkg::COORD_BITS-1:0] maj,
      input logic signed [lpr_pkg::COORD_BITS-1:0] min,
      input logic last);
    lpr_pkg::out_item_t p;
    p.pixel_x      = swapped ? min : maj;
    p.pixel_y      = swapped ? maj : min;
    p.pixel_colour = colour_held;
    p.last_pixel   = last;
    return p;
  endfunction

  function automatic void step_error();
    int acc;
    acc = int'(err_acc) + int'(err_incr);
    if (acc > int'(maj_delta)) begin
      min_pos = min_up ? min_pos + 12'sd1 : min_pos - 12'sd1;
      acc = acc - 2 * int'(maj_delta);
    end
    err_acc = lpr_pkg::ERR_BITS'(acc);
    maj_pos = maj_pos + 12'sd1;
  endfunction

  function automatic bit rasterize(input lpr_pkg::in_item_t b,
                                   output lpr_pkg::out_item_t p);
    int  x1, y1, x2, y2, a1, b1, a2, b2, t, dxa, dya;
    logic last;
    p = '0;
    if (b.req_type == lpr_pkg::REQ_LINE) begin
      x1 = int'(b.start_x);
      y1 = int'(b.start_y);
      x2 = int'(b.end_x);
      y2 = int'(b.end_y);
      colour_held = b.line_colour;
      if (x1 == x2 && y1 == y2) begin
        line_busy = 1'b0;
        swapped   = 1'b0;
        maj_pos   = lpr_pkg::COORD_BITS'(x1);
        maj_end   = lpr_pkg::COORD_BITS'(x1);
        min_pos   = lpr_pkg::COORD_BITS'(y1);
        min_up    = 1'b0;
        err_acc   = '0;
        err_incr  = '0;
        maj_delta = '0;
        p = pixel_at(maj_pos, min_pos, 1'b1);
        return 1'b1;
      end
      dxa = (x1 > x2) ? x1 - x2 : x2 - x1;
      dya = (y1 > y2) ? y1 - y2 : y2 - y1;
      swapped = dxa < dya;
      if (swapped) begin
        a1 = y1; b1 = x1; a2 = y2; b2 = x2;
      end else begin
        a1 = x1; b1 = y1; a2 = x2; b2 = y2;
      end
      if (a1 > a2) begin
        t = a1; a1 = a2; a2 = t;
        t = b1; b1 = b2; b2 = t;
      end
      maj_pos   = lpr_pkg::COORD_BITS'(a1);
      maj_end   = lpr_pkg::COORD_BITS'(a2);
      min_pos   = lpr_pkg::COORD_BITS'(b1);
      min_up    = b2 > b1;
      maj_delta = lpr_pkg::DELTA_BITS'(a2 - a1);
      err_incr  = lpr_pkg::INCR_BITS'(2 * ((b2 > b1) ? b2 - b1 : b1 - b2));
      err_acc   = '0;
      p = pixel_at(maj_pos, min_pos, 1'b0);
      step_error();
      line_busy = 1'b1;
      return 1'b1;
    end
    if (!line_busy)
      return 1'b0;
    last = maj_pos >= maj_end;
    p = pixel_at(maj_pos, min_pos, last);
    if (last)
      line_busy = 1'b0;
    else
      step_error();
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pred_some = rasterize(in_item, pred_pix);
        case (beat_check)
          BY_MODEL: begin
            if (pred_some)
              expected_pixels.push_back(pred_pix);
          end
          GIVEN_PIXEL: begin
            expected_pixels.push_back(given_pix);
          end
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pixel, expected none, got (%0d,%0d) %h last %0b",
                   $time, out_item.pixel_x, out_item.pixel_y, out_item.pixel_colour,
                   out_item.last_pixel);
        end else begin
          exp_pix = expected_pixels.pop_front();
          if (out_item.pixel_x !== exp_pix.pixel_x || out_item.pixel_y !== exp_pix.pixel_y ||
              out_item.pixel_colour !== exp_pix.pixel_colour ||
              out_item.last_pixel !== exp_pix.last_pixel) begin
            mismatches++;
            $display("%0t: expected (%0d,%0d) %h last %0b, got (%0d,%0d) %h last %0b",
                     $time, exp_pix.pixel_x, exp_pix.pixel_y, exp_pix.pixel_colour,
                     exp_pix.last_pixel, out_item.pixel_x, out_item.pixel_y,
                     out_item.pixel_colour, out_item.last_pixel);
          end
        end
      end
    end
  end

  // The long hold-off is counted here so that the sender keeps offering beats.
  always @(negedge clk) begin
    if (pressure_go && !pressure_done) begin
      hold_left = 64;
      pressure_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= (int'($urandom_range(0, 99)) < stall_pct);
    end
  end

  task automatic offer(input lpr_pkg::in_item_t b, input row_check_t chk,
                       input lpr_pkg::out_item_t pix);
    while (int'($urandom_range(0, 99)) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_item    <= b;
    beat_check <= chk;
    given_pix  <= pix;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void row(input logic req, input int sx, input int sy, input int ex,
                              input int ey, input logic [lpr_pkg::COLOUR_BITS-1:0] col,
                              input row_check_t chk, input int px, input int py,
                              input logic last);
    stim_row_t r;
    r.beat.req_type     = req;
    r.beat.start_x      = lpr_pkg::COORD_BITS'(sx);
    r.beat.start_y      = lpr_pkg::COORD_BITS'(sy);
    r.beat.end_x        = lpr_pkg::COORD_BITS'(ex);
    r.beat.end_y        = lpr_pkg::COORD_BITS'(ey);
    r.beat.line_colour  = col;
    r.check             = chk;
    r.pix.pixel_x       = lpr_pkg::COORD_BITS'(px);
    r.pix.pixel_y       = lpr_pkg::COORD_BITS'(py);
    r.pix.pixel_colour  = col;
    r.pix.last_pixel    = last;
    stim_table.push_back(r);
  endfunction

  function automatic int offset_coord(input int s, input int span);
    int d;
    d = int'($urandom_range(0, 2 * span)) - span;
    return (s + d > 2047 || s + d < -2048) ? s - d : s + d;
  endfunction

  function automatic lpr_pkg::in_item_t make_line();
    lpr_pkg::in_item_t b;
    int sx, sy, ex, ey, span;
    sx = int'($urandom_range(0, 4095)) - 2048;
    sy = int'($urandom_range(0, 4095)) - 2048;
    if ($urandom_range(0, 199) == 0) begin
      ex = int'($urandom_range(0, 4095)) - 2048;
      ey = int'($urandom_range(0, 4095)) - 2048;
    end else begin
      span = ($urandom_range(0, 9) == 0) ? 200 : 12;
      ex = offset_coord(sx, span);
      ey = offset_coord(sy, span);
      case ($urandom_range(0, 19))
        0: begin
          ex = sx;
          ey = sy;
        end
        1: begin
          ey = sy + (ex - sx);
          if (ey > 2047 || ey < -2048)
            ey = sy - (ex - sx);
        end
        default: begin
        end
      endcase
    end
    b.req_type    = lpr_pkg::REQ_LINE;
    b.start_x     = lpr_pkg::COORD_BITS'(sx);
    b.start_y     = lpr_pkg::COORD_BITS'(sy);
    b.end_x       = lpr_pkg::COORD_BITS'(ex);
    b.end_y       = lpr_pkg::COORD_BITS'(ey);
    b.line_colour = $urandom;
    return b;
  endfunction

  function automatic lpr_pkg::in_item_t make_tick();
    lpr_pkg::in_item_t b;
    b.req_type    = lpr_pkg::REQ_TICK;
    b.start_x     = lpr_pkg::COORD_BITS'($urandom);
    b.start_y     = lpr_pkg::COORD_BITS'($urandom);
    b.end_x       = lpr_pkg::COORD_BITS'($urandom);
    b.end_y       = lpr_pkg::COORD_BITS'($urandom);
    b.line_colour = $urandom;
    return b;
  endfunction

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    lpr_pkg::in_item_t b;
    int                items, ticks, dxa, dya, i;

    line_busy   = 1'b0;
    maj_pos     = '0;
    maj_end     = '0;
    min_pos     = '0;
    min_up      = 1'b0;
    swapped     = 1'b0;
    err_acc     = '0;
    err_incr    = '0;
    maj_delta   = '0;
    colour_held = '0;

    row(lpr_pkg::REQ_TICK, 0, 0, 0, 0, 32'h0, NO_PIXEL, 0, 0, 1'b0);
    row(lpr_pkg::REQ_LINE, 0, 0, 0, 0, 32'hFFFFFFFF, GIVEN_PIXEL, 0, 0, 1'b1);
    row(lpr_pkg::REQ_LINE, -2048, 2047, -2048, 2047, 32'h0, GIVEN_PIXEL, -2048, 2047, 1'b1);
    row(lpr_pkg::REQ_TICK, 0, 0, 0, 0, 32'h0, NO_PIXEL, 0, 0, 1'b0);
    row(lpr_pkg::REQ_LINE, 2047, -2048, 2044, -2048, 32'hA5A5A5A5, GIVEN_PIXEL,
        2044, -2048, 1'b0);
    repeat (3) row(lpr_pkg::REQ_TICK, 0, 0, 0, 0, 32'h0, BY_MODEL, 0, 0, 1'b0);
    row(lpr_pkg::REQ_TICK, 0, 0, 0, 0, 32'h0, NO_PIXEL, 0, 0, 1'b0);
    row(lpr_pkg::REQ_LINE, 0, 0, 1, 3, 32'h12345678, GIVEN_PIXEL, 0, 0, 1'b0);
    repeat (3) row(lpr_pkg::REQ_TICK, 0, 0, 0, 0, 32'h0, BY_MODEL, 0, 0, 1'b0);
    row(lpr_pkg::REQ_LINE, 0, 0, -2, 2, 32'h5A5A5A5A, GIVEN_PIXEL, -2, 2, 1'b0);
    repeat (2) row(lpr_pkg::REQ_TICK, 0, 0, 0, 0, 32'h0, BY_MODEL, 0, 0, 1'b0);
    row(lpr_pkg::REQ_LINE, 10, 10, 20, 15, 32'h0F0F0F0F, GIVEN_PIXEL, 10, 10, 1'b0);
    row(lpr_pkg::REQ_TICK, 0, 0, 0, 0, 32'h0, BY_MODEL, 0, 0, 1'b0);
    row(lpr_pkg::REQ_LINE, -5, -5, -5, -1, 32'hF0F0F0F0, GIVEN_PIXEL, -5, -5, 1'b0);
    repeat (4) row(lpr_pkg::REQ_TICK, 0, 0, 0, 0, 32'h0, BY_MODEL, 0, 0, 1'b0);
    row(lpr_pkg::REQ_TICK, 0, 0, 0, 0, 32'h0, NO_PIXEL, 0, 0, 1'b0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim_table[k])
      offer(stim_table[k].beat, stim_table[k].check, stim_table[k].pix);

    items = 0;
    pressure_go = 1'b1;
    while (items < N_ITEMS) begin
      case (items * 4 / N_ITEMS)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 79;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 79;
        end
        default: begin
          idle_pct = 33;
          stall_pct = 33;
        end
      endcase
      b = make_line();
      offer(b, BY_MODEL, '0);
      items++;
      dxa = int'(b.end_x) - int'(b.start_x);
      dya = int'(b.end_y) - int'(b.start_y);
      dxa = (dxa < 0) ? -dxa : dxa;
      dya = (dya < 0) ? -dya : dya;
      ticks = (dxa > dya) ? dxa : dya;
      // Some lines are cut short by the next command.
      if ($urandom_range(0, 4) == 0)
        ticks = int'($urandom_range(0, ticks));
      for (i = 0; i < ticks && items < N_ITEMS; i++) begin
        offer(make_tick(), BY_MODEL, '0);
        items++;
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) offer(make_tick(), BY_MODEL, '0);
    end

    in_valid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    while (expected_pixels.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_pixels.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
